[hdl/i2c_master_bit_engine_top_assert.svh]
// Assertion macros for the I2C bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CHK_IMPLIES(label, clk_s, rstn_s, a, b) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (a) |-> (b)) \
        else $error("i2c bit engine check failed");
`define CHK_NEXT(label, clk_s, rstn_s, a, b) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (a) |=> (b)) \
        else $error("i2c bit engine check failed");
`else
`define CHK_IMPLIES(label, clk_s, rstn_s, a, b)
`define CHK_NEXT(label, clk_s, rstn_s, a, b)
`endif
`endif

[hdl/i2c_mbe_pkg.sv]
`default_nettype none
package i2c_mbe_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 4'd1;

    localparam logic [CFG_DATA_W-1:0] WAIT_TICKS_RESET = 16'd600;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_ACK   = 3'd4;
    localparam logic [2:0] CMD_NACK  = 3'd5;
    localparam logic [2:0] CMD_STOP  = 3'd6;

    // Step where the bit loop of each byte command resumes.
    localparam logic [4:0] LOOP_TGT_WRITE = 5'd1;
    localparam logic [4:0] LOOP_TGT_READ  = 5'd2;
    localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

    typedef enum logic [3:0] {
        OP_END,
        OP_SCL_H,
        OP_SCL_L,
        OP_SDA_H,
        OP_SDA_L,
        OP_SDA_IN,
        OP_SDA_OUT,
        OP_WF,
        OP_WH,
        OP_SEND_BIT,
        OP_LOOP,
        OP_SAMPLE_ACK,
        OP_RX_BIT
    } op_t;

    typedef enum logic {
        SEQ_WAIT,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       sda_pin_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pin_out;
        logic       sda_released;
        logic       busy_res;
        logic       done_res;
        logic       ack_missing;
        logic [7:0] rx_byte;
    } result_t;

    // Pin program of each command, one step per phase.
    function automatic op_t prog_op(input logic [2:0] c, input logic [4:0] p);
        op_t op;
        op = OP_END;
        unique case (c)
            CMD_START: begin
                case (p)
                    5'd0: op = OP_SDA_OUT;
                    5'd1: op = OP_SDA_H;
                    5'd2: op = OP_SCL_H;
                    5'd3: op = OP_WF;
                    5'd4: op = OP_SDA_L;
                    5'd5: op = OP_WF;
                    5'd6: op = OP_WF;
                    5'd7: op = OP_SCL_L;
                    5'd8: op = OP_WF;
                    default: op = OP_END;
                endcase
            end
            CMD_WRITE: begin
                case (p)
                    5'd0:  op = OP_SCL_L;
                    5'd1:  op = OP_SEND_BIT;
                    5'd2:  op = OP_WF;
                    5'd3:  op = OP_SCL_H;
                    5'd4:  op = OP_WH;
                    5'd5:  op = OP_SCL_L;
                    5'd6:  op = OP_LOOP;
                    5'd7:  op = OP_SDA_H;
                    5'd8:  op = OP_WF;
                    5'd9:  op = OP_SDA_IN;
                    5'd10: op = OP_SCL_H;
                    5'd11: op = OP_WF;
                    5'd12: op = OP_SAMPLE_ACK;
                    5'd13: op = OP_SCL_L;
                    5'd14: op = OP_WF;
                    5'd15: op = OP_SDA_H;
                    5'd16: op = OP_SDA_OUT;
                    default: op = OP_END;
                endcase
            end
            CMD_READ: begin
                case (p)
                    5'd0:  op = OP_SDA_IN;
                    5'd1:  op = OP_SDA_H;
                    5'd2:  op = OP_SCL_L;
                    5'd3:  op = OP_WF;
                    5'd4:  op = OP_SCL_H;
                    5'd5:  op = OP_WH;
                    5'd6:  op = OP_RX_BIT;
                    5'd7:  op = OP_LOOP;
                    5'd8:  op = OP_WF;
                    5'd9:  op = OP_SCL_L;
                    5'd10: op = OP_SDA_OUT;
                    default: op = OP_END;
                endcase
            end
            CMD_ACK: begin
                case (p)
                    5'd0: op = OP_SCL_L;
                    5'd1: op = OP_WH;
                    5'd2: op = OP_SDA_L;
                    5'd3: op = OP_WF;
                    5'd4: op = OP_SCL_H;
                    5'd5: op = OP_WF;
                    5'd6: op = OP_SCL_L;
                    5'd7: op = OP_WF;
                    default: op = OP_END;
                endcase
            end
            CMD_NACK: begin
                case (p)
                    5'd0: op = OP_SDA_H;
                    5'd1: op = OP_SCL_L;
                    5'd2: op = OP_WF;
                    5'd3: op = OP_SCL_H;
                    5'd4: op = OP_WF;
                    5'd5: op = OP_SCL_L;
                    default: op = OP_END;
                endcase
            end
            CMD_STOP: begin
                case (p)
                    5'd0: op = OP_SDA_OUT;
                    5'd1: op = OP_SDA_L;
                    5'd2: op = OP_SCL_L;
                    5'd3: op = OP_WF;
                    5'd4: op = OP_SCL_H;
                    5'd5: op = OP_WF;
                    5'd6: op = OP_SDA_H;
                    default: op = OP_END;
                endcase
            end
            default: op = OP_END;
        endcase
        return op;
    endfunction

endpackage
`default_nettype wire

[hdl/i2c_mbe_fifo.sv]
`default_nettype none
module i2c_mbe_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    // Two-slot queue: head_reg always holds the oldest item.
    logic [WIDTH-1:0] head_reg;
    logic [WIDTH-1:0] head_next;
    logic [WIDTH-1:0] tail_reg;
    logic [WIDTH-1:0] tail_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rdata   = head_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    head_next = wdata;
                end
                else
                begin
                    tail_next = wdata;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    head_next = wdata;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = wdata;
                end
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
`default_nettype wire

[hdl/i2c_mbe_front.sv]
`default_nettype none
module i2c_mbe_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [2:0]      cmd,
    input  wire logic [7:0]      tx_byte,
    input  wire logic            sda_pin_in,
    input  wire logic            item_pop,
    output i2c_mbe_pkg::item_t   item,
    output logic                 item_empty
);
    import i2c_mbe_pkg::*;

    item_t             item_in;
    logic [2:0]        cmd_class;
    logic [$bits(item_t)-1:0] item_bits;

    // Undefined codes become a plain tick.
    always_comb
    begin
        unique case (cmd) inside
            CMD_START, CMD_WRITE, CMD_READ, CMD_ACK, CMD_NACK, CMD_STOP:
                cmd_class = cmd;
            default:
                cmd_class = CMD_NONE;
        endcase
    end

    assign item_in.cmd        = cmd_class;
    assign item_in.tx_byte    = tx_byte;
    assign item_in.sda_pin_in = sda_pin_in;

    i2c_mbe_fifo #(
        .WIDTH ($bits(item_t))
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item_in),
        .full  (full),
        .pop   (item_pop),
        .rdata (item_bits),
        .empty (item_empty)
    );

    assign item = item_t'(item_bits);

endmodule
`default_nettype wire

[hdl/i2c_mbe_back.sv]
`default_nettype none
module i2c_mbe_back #(
    parameter int WAIT_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [i2c_mbe_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [i2c_mbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire i2c_mbe_pkg::item_t                  item,
    input  wire logic                                item_empty,
    output logic                                     item_pop,
    input  wire logic                                res_full,
    output logic                                     res_push,
    output i2c_mbe_pkg::result_t                     res
);
    import i2c_mbe_pkg::*;

    seq_state_t              state_reg;
    seq_state_t              state_next;
    logic [CFG_DATA_W-1:0]   wait_ticks_reg;
    logic                    invert_reg;
    logic [2:0]              cmd_reg;
    logic [2:0]              cmd_next;
    logic [4:0]              phase_reg;
    logic [4:0]              phase_next;
    logic [3:0]              bit_cnt_reg;
    logic [3:0]              bit_cnt_next;
    logic [7:0]              shift_reg;
    logic [7:0]              shift_next;
    logic [WAIT_WIDTH-1:0]   wait_cnt_reg;
    logic [WAIT_WIDTH-1:0]   wait_cnt_next;
    logic                    scl_reg;
    logic                    scl_next;
    logic                    sda_reg;
    logic                    sda_next;
    logic                    rel_reg;
    logic                    rel_next;
    logic                    ack_reg;
    logic                    ack_next;
    logic [7:0]              rx_reg;
    logic [7:0]              rx_next;
    logic                    sample_reg;
    logic                    sample_next;

    op_t                              op;
    logic [WAIT_WIDTH+CFG_DATA_W-1:0] wait_ext;
    logic [WAIT_WIDTH-1:0]            wait_full;
    logic [WAIT_WIDTH-1:0]            wait_n;
    logic [3:0]                       bit_sum;
    logic                             need_run;
    logic                             tick_end;
    logic                             done;

    assign wait_ext  = {{WAIT_WIDTH{1'b0}}, wait_ticks_reg};
    assign wait_full = wait_ext[WAIT_WIDTH-1:0];
    assign op        = prog_op(cmd_reg, phase_reg);
    assign wait_n    = (op == OP_WH) ? (wait_full >> 1) : wait_full;
    assign bit_sum   = bit_cnt_reg + 4'd1;

    // A tick is taken only with room for its result downstream; the result
    // queue is filled by nothing else, so the room lasts until the tick ends.
    assign item_pop = (state_reg == SEQ_WAIT) && !item_empty && !res_full;

    always_comb
    begin
        cmd_next      = cmd_reg;
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        wait_cnt_next = wait_cnt_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        rel_next      = rel_reg;
        ack_next      = ack_reg;
        rx_next       = rx_reg;
        sample_next   = sample_reg;
        need_run      = 1'b0;
        tick_end      = 1'b0;
        done          = 1'b0;

        if (item_pop)
        begin
            sample_next = item.sda_pin_in ^ invert_reg;
            if ((cmd_reg == CMD_NONE) && (item.cmd != CMD_NONE))
            begin
                cmd_next      = item.cmd;
                phase_next    = 5'd0;
                wait_cnt_next = '0;
                bit_cnt_next  = 4'd0;
                if (item.cmd == CMD_WRITE)
                begin
                    shift_next = item.tx_byte;
                end
                else if (item.cmd == CMD_READ)
                begin
                    shift_next = 8'd0;
                end
                need_run = 1'b1;
            end
            else if (cmd_reg != CMD_NONE)
            begin
                if (wait_cnt_reg != '0)
                begin
                    wait_cnt_next = wait_cnt_reg - 1'b1;
                    tick_end      = 1'b1;
                end
                else
                begin
                    need_run = 1'b1;
                end
            end
            else
            begin
                tick_end = 1'b1;
            end
        end
        else if (state_reg == SEQ_RUN)
        begin
            phase_next = phase_reg + 5'd1;
            unique case (op) inside
                OP_SCL_H:    scl_next = 1'b1;
                OP_SCL_L:    scl_next = 1'b0;
                OP_SDA_H:    sda_next = 1'b1;
                OP_SDA_L:    sda_next = 1'b0;
                OP_SDA_IN:   rel_next = 1'b1;
                OP_SDA_OUT:  rel_next = 1'b0;
                OP_SEND_BIT: sda_next = shift_reg[7];
                OP_RX_BIT:   shift_next = {shift_reg[6:0], sample_reg};
                OP_WF, OP_WH:
                begin
                    // A zero-length wait costs no tick.
                    if (wait_n != '0)
                    begin
                        wait_cnt_next = wait_n - 1'b1;
                        tick_end      = 1'b1;
                    end
                end
                OP_LOOP:
                begin
                    if (cmd_reg == CMD_WRITE)
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                    end
                    bit_cnt_next = bit_sum;
                    if (bit_sum < BITS_PER_BYTE)
                    begin
                        phase_next = (cmd_reg == CMD_WRITE) ? LOOP_TGT_WRITE : LOOP_TGT_READ;
                    end
                end
                OP_SAMPLE_ACK:
                begin
                    ack_next = sample_reg;
                    if (sample_reg)
                    begin
                        // No acknowledge: drop the clock and end the command now.
                        scl_next   = 1'b0;
                        cmd_next   = CMD_NONE;
                        phase_next = 5'd0;
                        done       = 1'b1;
                        tick_end   = 1'b1;
                    end
                end
                default:
                begin
                    if (cmd_reg == CMD_READ)
                    begin
                        rx_next = shift_reg;
                    end
                    cmd_next   = CMD_NONE;
                    phase_next = 5'd0;
                    done       = 1'b1;
                    tick_end   = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (state_reg)
            SEQ_WAIT: state_next = need_run ? SEQ_RUN : SEQ_WAIT;
            SEQ_RUN:  state_next = tick_end ? SEQ_WAIT : SEQ_RUN;
            default:  state_next = SEQ_WAIT;
        endcase
    end

    always_comb
    begin
        res_push         = tick_end;
        res.scl_level    = scl_next;
        res.sda_pin_out  = sda_next ^ invert_reg;
        res.sda_released = rel_next;
        res.busy_res     = (cmd_next != CMD_NONE);
        res.done_res     = done;
        res.ack_missing  = ack_next;
        res.rx_byte      = rx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_ticks_reg <= WAIT_TICKS_RESET;
            invert_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_WAIT_TICKS)
            begin
                wait_ticks_reg <= cfg_data;
            end
            else if (cfg_idx == REG_INVERT)
            begin
                invert_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SEQ_WAIT;
            cmd_reg      <= CMD_NONE;
            phase_reg    <= 5'd0;
            bit_cnt_reg  <= 4'd0;
            shift_reg    <= 8'd0;
            wait_cnt_reg <= '0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            rel_reg      <= 1'b0;
            ack_reg      <= 1'b0;
            rx_reg       <= 8'd0;
            sample_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            wait_cnt_reg <= wait_cnt_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            rel_reg      <= rel_next;
            ack_reg      <= ack_next;
            rx_reg       <= rx_next;
            sample_reg   <= sample_next;
        end
    end

endmodule
`default_nettype wire

[hdl/i2c_master_bit_engine_top.sv]
// Channel   Handshake          Payload
// input     push / full        cmd, tx_byte, sda_pin_in
// result    empty / pop        scl_level, sda_pin_out, sda_released, busy_res,
//                              done_res, ack_missing, rx_byte
// config    cfg_we             cfg_idx, cfg_data (no wait, no read-back)
//
// Every item is one bus tick and gives exactly one result item.
// A tick that only counts down a wait runs no pin step; a tick that runs pin
// steps runs the sequencer step by step, up to the next nonzero wait or the
// end of the command.
// Two-entry queues at the input and the output let each side stall alone.
// Reset puts both lines high, SDA driven, and wait_ticks to 600.
`default_nettype none
`include "i2c_master_bit_engine_top_assert.svh"
module i2c_master_bit_engine_top #(
    parameter int WAIT_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [2:0]                          cmd,
    input  wire logic [7:0]                          tx_byte,
    input  wire logic                                sda_pin_in,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic                                     scl_level,
    output logic                                     sda_pin_out,
    output logic                                     sda_released,
    output logic                                     busy_res,
    output logic                                     done_res,
    output logic                                     ack_missing,
    output logic [7:0]                               rx_byte,
    input  wire logic                                cfg_we,
    input  wire logic [i2c_mbe_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [i2c_mbe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import i2c_mbe_pkg::*;

    item_t                      item;
    logic                       item_empty;
    logic                       item_pop;
    logic                       res_full;
    logic                       res_push;
    result_t                    res_in;
    logic [$bits(result_t)-1:0] res_bits;
    result_t                    res_out;

    i2c_mbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .tx_byte    (tx_byte),
        .sda_pin_in (sda_pin_in),
        .item_pop   (item_pop),
        .item       (item),
        .item_empty (item_empty)
    );

    i2c_mbe_back #(
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .item       (item),
        .item_empty (item_empty),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    i2c_mbe_fifo #(
        .WIDTH ($bits(result_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign res_out      = result_t'(res_bits);
    assign scl_level    = res_out.scl_level;
    assign sda_pin_out  = res_out.sda_pin_out;
    assign sda_released = res_out.sda_released;
    assign busy_res     = res_out.busy_res;
    assign done_res     = res_out.done_res;
    assign ack_missing  = res_out.ack_missing;
    assign rx_byte      = res_out.rx_byte;

    `CHK_IMPLIES(a_res_push_has_room, clk, rst_n, res_push, !res_full)
    `CHK_IMPLIES(a_item_pop_has_item, clk, rst_n, item_pop, !item_empty)
    `CHK_IMPLIES(a_done_not_busy, clk, rst_n, !empty && done_res, !busy_res)
    `CHK_NEXT(a_push_leaves_result, clk, rst_n, res_push, !empty)

endmodule
`default_nettype wire

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_mbe_pkg::*;

    localparam logic [2:0] CMD_UNDEF = 3'd7;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned LIMIT_CYCLES = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = 200;

    typedef struct {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [2:0]            cmd;
        logic [7:0]            tx;
        logic                  pin;
        logic                  chk;
        result_t               want;
    } step_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [2:0]            cmd = CMD_NONE;
    logic [7:0]            tx_byte = 8'h00;
    logic                  sda_pin_in = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  scl_level;
    logic                  sda_pin_out;
    logic                  sda_released;
    logic                  busy_res;
    logic                  done_res;
    logic                  ack_missing;
    logic [7:0]            rx_byte;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = REG_WAIT_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Bus engine state as the predictor sees it.
    logic [CFG_DATA_W-1:0] wait_ticks_reg = WAIT_TICKS_RESET;
    logic                  invert_reg = 1'b0;
    logic [2:0]            bus_cmd = CMD_NONE;
    logic [4:0]            bus_phase = '0;
    logic [3:0]            bus_bits = '0;
    logic [7:0]            bus_shift = '0;
    logic [15:0]           bus_wait = '0;
    logic                  bus_scl = 1'b1;
    logic                  bus_sda = 1'b1;
    logic                  bus_ack = 1'b0;
    logic [7:0]            bus_rx = '0;
    logic                  bus_rel = 1'b0;

    result_t               tick_results_q[$];
    logic [2:0]            txn_q[$];
    step_row_t             plan[$];
    int unsigned           mismatches = 0;
    int unsigned           send_calm = 0;
    int unsigned           recv_calm = 0;

    i2c_master_bit_engine_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .tx_byte      (tx_byte),
        .sda_pin_in   (sda_pin_in),
        .empty        (empty),
        .pop          (pop),
        .scl_level    (scl_level),
        .sda_pin_out  (sda_pin_out),
        .sda_released (sda_released),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .ack_missing  (ack_missing),
        .rx_byte      (rx_byte),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic op_t seq_op(input logic [2:0] c, input logic [4:0] p);
        op_t ops[$];
        case (c)
            CMD_START: ops = {OP_SDA_OUT, OP_SDA_H, OP_SCL_H, OP_WF, OP_SDA_L, OP_WF, OP_WF,
                              OP_SCL_L, OP_WF};
            CMD_WRITE: ops = {OP_SCL_L, OP_SEND_BIT, OP_WF, OP_SCL_H, OP_WH, OP_SCL_L, OP_LOOP,
                              OP_SDA_H, OP_WF, OP_SDA_IN, OP_SCL_H, OP_WF, OP_SAMPLE_ACK,
                              OP_SCL_L, OP_WF, OP_SDA_H, OP_SDA_OUT};
            CMD_READ:  ops = {OP_SDA_IN, OP_SDA_H, OP_SCL_L, OP_WF, OP_SCL_H, OP_WH, OP_RX_BIT,
                              OP_LOOP, OP_WF, OP_SCL_L, OP_SDA_OUT};
            CMD_ACK:   ops = {OP_SCL_L, OP_WH, OP_SDA_L, OP_WF, OP_SCL_H, OP_WF, OP_SCL_L, OP_WF};
            CMD_NACK:  ops = {OP_SDA_H, OP_SCL_L, OP_WF, OP_SCL_H, OP_WF, OP_SCL_L};
            CMD_STOP:  ops = {OP_SDA_OUT, OP_SDA_L, OP_SCL_L, OP_WF, OP_SCL_H, OP_WF, OP_SDA_H};
            default: ;
        endcase
        if (p < ops.size())
            return ops[p];
        return OP_END;
    endfunction

    // One bus tick: accept a command if idle, then count down the wait or run
    // pin steps up to the next nonzero wait or the end of the command.
    function automatic result_t bus_tick(input logic [2:0] c, input logic [7:0] tx,
                                         input logic pin);
        logic        bit_in;
        logic        fin;
        logic        run;
        op_t         op;
        logic [15:0] n;
        result_t     r;
        bit_in = pin ^ invert_reg;
        fin = 1'b0;
        if (bus_cmd == CMD_NONE && c >= CMD_START && c <= CMD_STOP)
        begin
            bus_cmd = c;
            bus_phase = '0;
            bus_wait = '0;
            bus_bits = '0;
            if (c == CMD_WRITE)
                bus_shift = tx;
            else if (c == CMD_READ)
                bus_shift = '0;
        end
        if (bus_cmd != CMD_NONE)
        begin
            if (bus_wait != 0)
            begin
                bus_wait = bus_wait - 16'd1;
            end
            else
            begin
                run = 1'b1;
                while (run)
                begin
                    op = seq_op(bus_cmd, bus_phase);
                    case (op)
                        OP_SCL_H:   begin bus_scl = 1'b1; bus_phase = bus_phase + 5'd1; end
                        OP_SCL_L:   begin bus_scl = 1'b0; bus_phase = bus_phase + 5'd1; end
                        OP_SDA_H:   begin bus_sda = 1'b1; bus_phase = bus_phase + 5'd1; end
                        OP_SDA_L:   begin bus_sda = 1'b0; bus_phase = bus_phase + 5'd1; end
                        OP_SDA_IN:  begin bus_rel = 1'b1; bus_phase = bus_phase + 5'd1; end
                        OP_SDA_OUT: begin bus_rel = 1'b0; bus_phase = bus_phase + 5'd1; end
                        OP_WF, OP_WH:
                        begin
                            n = (op == OP_WH) ? (wait_ticks_reg >> 1) : wait_ticks_reg;
                            bus_phase = bus_phase + 5'd1;
                            // The tick that reaches a wait is its first tick.
                            if (n != 0)
                            begin
                                bus_wait = n - 16'd1;
                                run = 1'b0;
                            end
                        end
                        OP_SEND_BIT:
                        begin
                            bus_sda = bus_shift[7];
                            bus_phase = bus_phase + 5'd1;
                        end
                        OP_RX_BIT:
                        begin
                            bus_shift = {bus_shift[6:0], bit_in};
                            bus_phase = bus_phase + 5'd1;
                        end
                        OP_LOOP:
                        begin
                            if (bus_cmd == CMD_WRITE)
                                bus_shift = bus_shift << 1;
                            bus_bits = bus_bits + 4'd1;
                            if (bus_bits < BITS_PER_BYTE)
                                bus_phase = (bus_cmd == CMD_WRITE) ? LOOP_TGT_WRITE
                                                                    : LOOP_TGT_READ;
                            else
                                bus_phase = bus_phase + 5'd1;
                        end
                        OP_SAMPLE_ACK:
                        begin
                            // A high data line here means no ack: the write stops at once.
                            if (bit_in)
                            begin
                                bus_ack = 1'b1;
                                bus_scl = 1'b0;
                                fin = 1'b1;
                                run = 1'b0;
                            end
                            else
                            begin
                                bus_ack = 1'b0;
                                bus_phase = bus_phase + 5'd1;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                            run = 1'b0;
                        end
                    endcase
                end
                if (fin)
                begin
                    if (bus_cmd == CMD_READ)
                        bus_rx = bus_shift;
                    bus_cmd = CMD_NONE;
                    bus_phase = '0;
                end
            end
        end
        r.scl_level = bus_scl;
        r.sda_pin_out = bus_sda ^ invert_reg;
        r.sda_released = bus_rel;
        r.busy_res = (bus_cmd != CMD_NONE);
        r.done_res = fin;
        r.ack_missing = bus_ack;
        r.rx_byte = bus_rx;
        return r;
    endfunction

    function automatic result_t res(input logic scl, input logic sda, input logic rel,
                                    input logic busy, input logic done, input logic ack,
                                    input logic [7:0] rx);
        return {scl, sda, rel, busy, done, ack, rx};
    endfunction

    function automatic step_row_t item_row(input logic [2:0] c, input logic [7:0] tx,
                                           input logic pin, input logic chk,
                                           input result_t want);
        step_row_t row;
        row.is_cfg = 1'b0;
        row.idx = '0;
        row.data = '0;
        row.cmd = c;
        row.tx = tx;
        row.pin = pin;
        row.chk = chk;
        row.want = want;
        return row;
    endfunction

    function automatic step_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        step_row_t row;
        row = item_row(CMD_NONE, 8'h00, 1'b0, 1'b0, '0);
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    // Random pause before the next item, with stretches of none at all.
    function automatic int unsigned draw_pause(inout int unsigned calm);
        if (calm != 0)
        begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            calm = $urandom_range(20, 80);
        return $urandom_range(0, 15);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic put_item(input logic [2:0] c, input logic [7:0] tx, input logic pin,
                            input logic chk, input result_t want);
        int unsigned gap;
        result_t     predicted;
        cfg_we <= 1'b0;
        gap = draw_pause(send_calm);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        cmd <= c;
        tx_byte <= tx;
        sda_pin_in <= pin;
        @(posedge clk);
        while (full) @(posedge clk);
        predicted = bus_tick(c, tx, pin);
        tick_results_q.push_back(chk ? want : predicted);
    endtask

    // The write enable is left high here; the next item lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        push <= 1'b0;
        while (tick_results_q.size() != 0) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        if (idx == REG_WAIT_TICKS)
            wait_ticks_reg = data;
        else if (idx == REG_INVERT)
            invert_reg = data[0];
    endtask

    function automatic void plan_transaction();
        int unsigned n;
        if ($urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 4);
            repeat (n) txn_q.push_back(3'($urandom_range(CMD_START, CMD_STOP)));
        end
        else
        begin
            n = $urandom_range(0, 3);
            txn_q.push_back(CMD_START);
            txn_q.push_back(CMD_WRITE);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    txn_q.push_back(CMD_WRITE);
                end
                else
                begin
                    txn_q.push_back(CMD_READ);
                    if (i == n - 1 || $urandom_range(0, 3) == 0)
                        txn_q.push_back(CMD_NACK);
                    else
                        txn_q.push_back(CMD_ACK);
                end
            end
            txn_q.push_back(CMD_STOP);
        end
    endfunction

    // Commands from well-formed transactions while idle, with some idle
    // ticks and stray codes; anything goes while a command runs.
    task automatic random_tick();
        logic [2:0]  c;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (bus_cmd != CMD_NONE || r == 0)
        begin
            c = 3'($urandom_range(0, 7));
        end
        else if (r <= 2)
        begin
            c = ($urandom_range(0, 1) == 0) ? CMD_NONE : CMD_UNDEF;
        end
        else
        begin
            if (txn_q.size() == 0)
                plan_transaction();
            c = txn_q.pop_front();
        end
        put_item(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    initial
    begin : stimulus
        int unsigned n_random;
        int unsigned phase_no;
        int unsigned len;
        logic [15:0] w;
        n_random = 0;
        phase_no = 0;

        plan.push_back(item_row(CMD_NONE, 8'h00, 1'b0, 1'b1, res(1, 1, 0, 0, 0, 0, 8'h00)));
        plan.push_back(item_row(CMD_UNDEF, 8'hFF, 1'b1, 1'b1, res(1, 1, 0, 0, 0, 0, 8'h00)));
        // With no wait every command runs whole on its first tick.
        plan.push_back(reg_row(REG_WAIT_TICKS, 16'd0));
        plan.push_back(reg_row(REG_INVERT, 16'd0));
        plan.push_back(item_row(CMD_START, 8'h00, 1'b1, 1'b1, res(0, 0, 0, 0, 1, 0, 8'h00)));
        plan.push_back(item_row(CMD_WRITE, 8'hFF, 1'b1, 1'b1, res(0, 1, 1, 0, 1, 1, 8'h00)));
        plan.push_back(item_row(CMD_READ, 8'h00, 1'b1, 1'b1, res(0, 1, 0, 0, 1, 1, 8'hFF)));
        plan.push_back(item_row(CMD_WRITE, 8'h00, 1'b0, 1'b1, res(0, 1, 0, 0, 1, 0, 8'hFF)));
        plan.push_back(item_row(CMD_READ, 8'h00, 1'b0, 1'b1, res(0, 1, 0, 0, 1, 0, 8'h00)));
        plan.push_back(item_row(CMD_ACK, 8'h00, 1'b0, 1'b1, res(0, 0, 0, 0, 1, 0, 8'h00)));
        plan.push_back(item_row(CMD_NACK, 8'h00, 1'b0, 1'b1, res(0, 1, 0, 0, 1, 0, 8'h00)));
        plan.push_back(item_row(CMD_STOP, 8'h00, 1'b0, 1'b1, res(1, 1, 0, 0, 1, 0, 8'h00)));
        plan.push_back(reg_row(REG_INVERT, 16'd1));
        plan.push_back(item_row(CMD_NONE, 8'h00, 1'b1, 1'b1, res(1, 0, 0, 0, 0, 0, 8'h00)));
        plan.push_back(item_row(CMD_READ, 8'h00, 1'b0, 1'b1, res(0, 0, 0, 0, 1, 0, 8'hFF)));
        plan.push_back(item_row(CMD_WRITE, 8'hA5, 1'b0, 1'b1, res(0, 0, 1, 0, 1, 1, 8'hFF)));
        // A running command ignores new codes, even on its last tick, and a
        // new wait length takes effect at the next wait it reaches.
        plan.push_back(reg_row(REG_WAIT_TICKS, 16'd1));
        plan.push_back(item_row(CMD_START, 8'h00, 1'b0, 1'b0, '0));
        plan.push_back(item_row(CMD_STOP, 8'h00, 1'b0, 1'b0, '0));
        plan.push_back(item_row(CMD_READ, 8'h00, 1'b1, 1'b0, '0));
        plan.push_back(reg_row(REG_WAIT_TICKS, 16'd3));
        plan.push_back(item_row(CMD_ACK, 8'h00, 1'b0, 1'b0, '0));
        plan.push_back(item_row(CMD_WRITE, 8'h3C, 1'b1, 1'b0, '0));
        plan.push_back(item_row(CMD_NONE, 8'h00, 1'b0, 1'b0, '0));
        plan.push_back(item_row(CMD_NACK, 8'h00, 1'b1, 1'b0, '0));
        plan.push_back(item_row(CMD_STOP, 8'h00, 1'b0, 1'b0, '0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].idx, plan[i].data);
            else
                put_item(plan[i].cmd, plan[i].tx, plan[i].pin, plan[i].chk, plan[i].want);
        end

        while (n_random < RANDOM_ITEMS)
        begin
            if (phase_no == 2)
            begin
                // Longest wait: only idle ticks, since a command would run for ages.
                write_reg(REG_WAIT_TICKS, 16'hFFFF);
                write_reg(REG_INVERT, 16'($urandom_range(0, 1)));
                repeat (16)
                begin
                    put_item(($urandom_range(0, 1) == 0) ? CMD_NONE : CMD_UNDEF,
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
                    n_random++;
                end
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: w = 16'd0;
                    3, 4, 5: w = 16'($urandom_range(1, 3));
                    6, 7, 8: w = 16'($urandom_range(4, 9));
                    default: w = 16'($urandom_range(10, 24));
                endcase
                write_reg(REG_WAIT_TICKS, w);
                write_reg(REG_INVERT, 16'($urandom_range(0, 1)));
                len = $urandom_range(60, 200);
                repeat (len)
                begin
                    random_tick();
                    n_random++;
                end
                // Let the running command finish so the next phase starts idle.
                while (bus_cmd != CMD_NONE)
                begin
                    random_tick();
                    n_random++;
                end
            end
            phase_no++;
        end

        push <= 1'b0;
        while (tick_results_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("i2c_master_bit_engine_top test passed");
        else
            $display("i2c_master_bit_engine_top test failed");
        $finish;
    end

    initial
    begin : result_side
        int unsigned stall;
        result_t     want;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = draw_pause(recv_calm);
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            if (tick_results_q.size() == 0)
            begin
                $error("result item arrived with nothing expected");
                mismatches++;
            end
            else
            begin
                want = tick_results_q.pop_front();
                check_field("scl_level", 8'(want.scl_level), 8'(scl_level));
                check_field("sda_pin_out", 8'(want.sda_pin_out), 8'(sda_pin_out));
                check_field("sda_released", 8'(want.sda_released), 8'(sda_released));
                check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
                check_field("done_res", 8'(want.done_res), 8'(done_res));
                check_field("ack_missing", 8'(want.ack_missing), 8'(ack_missing));
                check_field("rx_byte", want.rx_byte, rx_byte);
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("i2c_master_bit_engine_top test failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/i2c_mbe_pkg.sv
hdl/i2c_mbe_fifo.sv
hdl/i2c_mbe_front.sv
hdl/i2c_mbe_back.sv
hdl/i2c_master_bit_engine_top.sv
dv/tb.sv
